// ----- hw/rtl/ritp_pkg.sv -----
// Shared types and constants of the radix integer token parser.
package ritp_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned BASE_W = 6;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 6;
    localparam int unsigned RITP_QUEUE_DEPTH = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_RADIX = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_SIGNED_MODE = 1'b1;

    localparam logic [BASE_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
    localparam logic [BASE_W-1:0] BASE_TEN = 6'd10;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_NO_DIGIT = 3'd2,
        ST_BAD_DIGIT = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    // One classified input byte as the back end needs it.
    typedef struct packed {
        logic              eoi;
        logic [CHAR_W-1:0] ch;
        logic              blank;
        logic              line_break;
        logic              plus;
        logic              minus;
        logic              dig_ok;
        logic              dig_bad;
        logic [BASE_W-1:0] dig;
        logic [BASE_W-1:0] base;
        logic              sgn;
    } entry_t;

endpackage

// ----- hw/rtl/ritp_front.sv -----
// Front end: configuration registers and classification of each input byte.
module ritp_front
    import ritp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [CHAR_W-1:0]     char_in,
    input  logic                  end_of_input,
    output entry_t                entry
);

    logic [BASE_W-1:0] radix_reg;
    logic              signed_mode_reg;
    logic [BASE_W-1:0] base;
    logic              letters;
    logic [CHAR_W-1:0] c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
            signed_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_IDX_RADIX: radix_reg <= cfg_wdata;
                CFG_IDX_SIGNED_MODE: signed_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign c = char_in;
    assign letters = base > BASE_TEN;

    always_comb begin
        priority if (signed_mode_reg) begin
            base = BASE_TEN;
        end else if (radix_reg < BASE_MIN) begin
            base = BASE_MIN;
        end else if (radix_reg > BASE_MAX) begin
            base = BASE_MAX;
        end else begin
            base = radix_reg;
        end
    end

    always_comb begin
        entry.eoi = end_of_input;
        entry.ch = c;
        entry.blank = (c == 8'h00) || (c == 8'h20) || (c == 8'hA0) || (c == 8'h09);
        entry.line_break = (c >= 8'h0A) && (c <= 8'h0D);
        entry.plus = (c == 8'h2B);
        entry.minus = (c == 8'h2D);
        entry.base = base;
        entry.sgn = signed_mode_reg;
        entry.dig_ok = 1'b0;
        entry.dig = '0;
        priority if ((c >= 8'h30) && (c <= 8'h39)) begin
            entry.dig_ok = 1'b1;
            entry.dig = BASE_W'(c - 8'h30);
        end else if (letters && (c >= 8'h61) && (c <= 8'h7A)) begin
            entry.dig_ok = 1'b1;
            entry.dig = BASE_W'(c - 8'h61 + 8'd10);
        end else if (letters && (c >= 8'h41) && (c <= 8'h5A)) begin
            entry.dig_ok = 1'b1;
            entry.dig = BASE_W'(c - 8'h41 + 8'd10);
        end else begin
            entry.dig_ok = 1'b0;
        end
        entry.dig_bad = entry.dig >= base;
    end

endmodule

// ----- hw/rtl/ritp_queue.sv -----
// Short queue of classified bytes between the front end and the back end.
module ritp_queue
    import ritp_pkg::*;
#(
    parameter int unsigned DEPTH = RITP_QUEUE_DEPTH
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output entry_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue count exceeds its depth");

    a_push_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (full && push && !pop) |=> full && $stable(wr_ptr_reg))
        else $error("queue accepted an entry while full");

    a_pop_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && not_empty && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue pop did not reduce the count");

endmodule

// ----- hw/rtl/ritp_back.sv -----
// Back end: token state machine, accumulate step and output register.
module ritp_back
    import ritp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_not_empty,
    input  entry_t              q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [VALUE_W-1:0]  m_value,
    output logic [STATUS_W-1:0] m_status,
    output logic [CHAR_W-1:0]   m_stop_char,
    output logic                m_stop_is_end
);

    localparam int unsigned PROD_W = VALUE_W + BASE_W + 1;

    typedef enum logic [1:0] {
        PH_SKIP = 2'd0,
        PH_SIGN = 2'd1,
        PH_DIGITS = 2'd2
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [VALUE_W-1:0]  acc_reg, acc_next;
    logic                neg_reg, neg_next;
    logic                m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]  m_value_reg, m_value_next;
    status_t             m_status_reg, m_status_next;
    logic [CHAR_W-1:0]   m_stop_char_reg, m_stop_char_next;
    logic                m_stop_is_end_reg, m_stop_is_end_next;

    logic                emit;
    status_t             em_status;
    logic [VALUE_W-1:0]  em_value;
    logic [CHAR_W-1:0]   em_char;
    logic                em_end;
    logic [PROD_W-1:0]   prod;
    logic                prod_ovf;
    logic                ovf_pos;
    logic                ovf_neg;

    assign q_pop = q_not_empty && (!m_valid_reg || m_ready);

    assign prod = ({{(PROD_W-VALUE_W){1'b0}}, acc_reg}
                   * {{(PROD_W-BASE_W){1'b0}}, q_head.base})
                  + {{(PROD_W-BASE_W){1'b0}}, q_head.dig};
    assign prod_ovf = (prod[PROD_W-1:VALUE_W] != '0);
    assign ovf_pos = acc_reg[VALUE_W-1];
    assign ovf_neg = acc_reg[VALUE_W-1] && (acc_reg[VALUE_W-2:0] != '0);

    always_comb begin
        phase_next = phase_reg;
        acc_next = acc_reg;
        neg_next = neg_reg;
        emit = 1'b0;
        em_status = ST_OK;
        em_value = '0;
        em_char = q_head.ch;
        em_end = 1'b0;

        if (q_pop) begin
            if (phase_reg == PH_DIGITS) begin
                if (q_head.eoi || !q_head.dig_ok) begin
                    // The token ends here.
                    emit = 1'b1;
                    em_end = q_head.eoi;
                    em_char = q_head.eoi ? '0 : q_head.ch;
                    if (!q_head.sgn) begin
                        em_value = acc_reg;
                    end else if (!neg_reg) begin
                        em_status = ovf_pos ? ST_OVERFLOW : ST_OK;
                        em_value = ovf_pos ? '0 : acc_reg;
                    end else begin
                        em_status = ovf_neg ? ST_OVERFLOW : ST_OK;
                        em_value = ovf_neg ? '0 : ('0 - acc_reg);
                    end
                end else if (q_head.dig_bad) begin
                    emit = 1'b1;
                    em_status = ST_BAD_DIGIT;
                end else if (prod_ovf) begin
                    emit = 1'b1;
                    em_status = ST_OVERFLOW;
                end else begin
                    acc_next = prod[VALUE_W-1:0];
                end
            end else begin
                priority if (q_head.eoi) begin
                    emit = 1'b1;
                    em_status = ST_NOT_FOUND;
                    em_char = '0;
                    em_end = 1'b1;
                end else if (q_head.blank) begin
                    emit = 1'b0;
                end else if (q_head.line_break) begin
                    emit = 1'b1;
                    em_status = ST_NOT_FOUND;
                end else if ((phase_reg != PH_SIGN) && q_head.sgn
                             && (q_head.plus || q_head.minus)) begin
                    neg_next = q_head.minus;
                    phase_next = PH_SIGN;
                end else if (!q_head.dig_ok) begin
                    emit = 1'b1;
                    em_status = ST_NO_DIGIT;
                end else if (q_head.dig_bad) begin
                    emit = 1'b1;
                    em_status = ST_BAD_DIGIT;
                end else if (prod_ovf) begin
                    emit = 1'b1;
                    em_status = ST_OVERFLOW;
                end else begin
                    acc_next = prod[VALUE_W-1:0];
                    phase_next = PH_DIGITS;
                end
            end
            if (emit) begin
                phase_next = PH_SKIP;
                acc_next = '0;
                neg_next = 1'b0;
            end
        end

        m_valid_next = m_valid_reg && !m_ready;
        m_value_next = m_value_reg;
        m_status_next = m_status_reg;
        m_stop_char_next = m_stop_char_reg;
        m_stop_is_end_next = m_stop_is_end_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_value_next = em_value;
            m_status_next = em_status;
            m_stop_char_next = em_char;
            m_stop_is_end_next = em_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SKIP;
            acc_reg <= '0;
            neg_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            acc_reg <= acc_next;
            neg_reg <= neg_next;
            m_valid_reg <= m_valid_next;
        end
        m_value_reg <= m_value_next;
        m_status_reg <= m_status_next;
        m_stop_char_reg <= m_stop_char_next;
        m_stop_is_end_reg <= m_stop_is_end_next;
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_status = m_status_reg;
    assign m_stop_char = m_stop_char_reg;
    assign m_stop_is_end = m_stop_is_end_reg;

    a_error_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != ST_OK)) |-> (m_value_reg == '0))
        else $error("error result carries a nonzero value");

    a_end_zero_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_stop_is_end_reg) |-> (m_stop_char_reg == '0))
        else $error("end of input result carries a stop byte");

    a_emit_clears_token: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (phase_reg == PH_SKIP) && (acc_reg == '0) && !neg_reg)
        else $error("token state not cleared after a result");

    a_no_pop_while_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !q_pop)
        else $error("queue popped while the output register is blocked");

endmodule

// ----- hw/rtl/radix_integer_token_parser_core.sv -----
// Top level of the streaming radix integer token parser.
//
// Bytes of a text stream enter on the s_ channel, one per transaction, with
// s_end_of_input marking the end of the stream. Each integer token, and
// each line break, bad byte or end of input outside a token, yields one
// result transaction on the m_ channel: value, status, the byte that ended
// the token and whether end of input ended it. Bytes that are skipped or
// absorbed into a token give no result. The cfg_ port writes the radix
// (index 0) and signed mode (index 1); the user must write them only while
// the block is idle; the block does not enforce it. A front end classifies
// each byte against the current configuration into a two-entry queue; the
// back end takes one entry, and so one byte, per cycle while the output
// register is not blocked, doing one 64-by-6 multiply-add and overflow
// check. A receiver stall holds the result in the output register, stops
// the back end and fills the queue; then s_ready falls. Reset clears the
// queue, the token state and m_valid, and sets radix 10 and unsigned mode.
module radix_integer_token_parser_core
    import ritp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = RITP_QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CHAR_W-1:0]     s_char_in,
    input  logic                  s_end_of_input,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_W-1:0]    m_value,
    output logic [STATUS_W-1:0]   m_status,
    output logic [CHAR_W-1:0]     m_stop_char,
    output logic                  m_stop_is_end
);

    entry_t front_entry;
    entry_t q_head;
    logic   q_full;
    logic   q_not_empty;
    logic   q_pop;

    assign s_ready = !q_full;

    ritp_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .char_in      (s_char_in),
        .end_of_input (s_end_of_input),
        .entry        (front_entry)
    );

    ritp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_data (front_entry),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    ritp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_not_empty   (q_not_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_status      (m_status),
        .m_stop_char   (m_stop_char),
        .m_stop_is_end (m_stop_is_end)
    );

endmodule
